[design/vvr_pkg.sv]
`timescale 1ns / 1ps

package vvr_pkg;

    // cube geometry
    localparam int CUBE_EDGE = 8;
    localparam int COORD_W   = 3;
    localparam int ROW_AW    = 2 * COORD_W;
    localparam int ROW_DEPTH = CUBE_EDGE * CUBE_EDGE;
    localparam int WALK_W    = 3 * COORD_W;
    localparam int CENTRE2   = CUBE_EDGE - 1;

    // angle and trig widths
    localparam int ANGLE_W = 8;
    localparam int TRIG_W  = 9;
    localparam int AXIS_W  = 2;

    // rotation plane codes
    localparam logic [AXIS_W-1:0] AXIS_XY = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_XZ = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YZ = 2'd2;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // offset sine, 128 is zero
    localparam logic [7:0] SINE_TABLE [256] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
        8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
        8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
        8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
        8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
        8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
        8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
        8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
        8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
        8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
        8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
        8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
        8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
        8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
        8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
        8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
        8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
        8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
        8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
        8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
        8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
        8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
        8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
        8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
        8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
        8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
        8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
    };

    // input item
    typedef struct packed {
        logic               cmd;
        logic [2:0]         layer_index;
        logic [2:0]         row_index;
        logic [7:0]         row_bits;
        logic [ANGLE_W-1:0] angle;
        logic               counter_clockwise;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [2:0] out_layer;
        logic [2:0] out_row;
        logic [7:0] out_bits;
        logic       last;
    } out_item_t;

    // voxel walk position, one per cycle
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } walk_t;

    // target voxel update
    typedef struct packed {
        logic               valid;
        logic [ROW_AW-1:0]  addr;
        logic [COORD_W-1:0] bitpos;
    } upd_t;

endpackage

[design/voxel_volume_rotator.sv]
`timescale 1ns / 1ps

// 8x8x8 one-bit voxel volume rotator
// req channel (req_valid, req_stall, req_item): a load item writes one source
// row; a render item rotates the stored volume by angle about the plane held
// in the configuration register and returns 64 target rows.
// rsp channel (rsp_valid, rsp_stall, rsp_item): rows in order layer 0..7, row
// 0..7 within a layer, last set on the final row.
// cfg channel (cfg_valid, cfg_ready, cfg_data): 2-bit rotation plane, always
// ready; write it only while no render is in progress.
// a render walks all 512 voxels one per cycle through read-modify-write of the
// target memory, drains the walk, mapper and write-back registers, then reads
// out 64 rows one per cycle while the receiver does not stall. A load leaves
// req_stall low, so another item can follow it.
// req_stall is high from a render transfer until its last row is loaded into
// the output register; the output register holds a stalled row unchanged.
// reset clears source and target volumes, the plane register and all control.

module voxel_volume_rotator
    import vvr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  in_item_t          req_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output out_item_t         rsp_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [AXIS_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [AXIS_W-1:0]         axis_reg;
    logic [WALK_W-1:0]         walk_cnt_reg;
    logic [WALK_W-1:0]         walk_cnt_next;
    walk_t                     walk_reg;
    walk_t                     walk_next;
    logic [ROW_AW-1:0]         emit_idx_reg;
    logic [ROW_AW-1:0]         emit_idx_next;
    logic signed [TRIG_W-1:0]  sin_reg;
    logic signed [TRIG_W-1:0]  cos_reg;
    logic [ANGLE_W-1:0]        angle_eff;
    logic [ANGLE_W-1:0]        cos_idx;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    out_item_t                 rsp_item_reg;
    logic                      req_xfer;
    logic                      load_xfer;
    logic                      render_xfer;
    logic                      out_load;
    logic [CUBE_EDGE-1:0]      src_bits;
    logic [CUBE_EDGE-1:0]      emit_bits;
    logic                      tgt_busy;
    upd_t                      upd;

    assign req_stall   = (state_reg != ST_IDLE);
    assign req_xfer    = req_valid && !req_stall;
    assign load_xfer   = req_xfer && (req_item.cmd == CMD_LOAD);
    assign render_xfer = req_xfer && (req_item.cmd == CMD_RENDER);
    assign cfg_ready   = 1'b1;

    // angle direction and sine/negated cosine lookup
    assign angle_eff = req_item.counter_clockwise ? req_item.angle
                                                   : ANGLE_W'(8'd0 - req_item.angle);
    assign cos_idx   = angle_eff - ANGLE_W'(64);

    always_ff @(posedge clk)
    begin
        if (render_xfer)
        begin
            sin_reg <= signed'({1'b0, SINE_TABLE[angle_eff]}) - 9'sd128;
            cos_reg <= signed'({1'b0, SINE_TABLE[cos_idx]}) - 9'sd128;
        end
    end

    // rotation plane register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_XY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            axis_reg <= cfg_data;
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!rsp_valid_reg || !rsp_stall);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        walk_cnt_next = walk_cnt_reg;
        emit_idx_next = emit_idx_reg;
        walk_next     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (render_xfer)
                begin
                    walk_cnt_next = '0;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                walk_next.valid = 1'b1;
                walk_next.z     = walk_cnt_reg[WALK_W-1:2*COORD_W];
                walk_next.y     = walk_cnt_reg[2*COORD_W-1:COORD_W];
                walk_next.x     = walk_cnt_reg[COORD_W-1:0];
                walk_cnt_next   = walk_cnt_reg + WALK_W'(1);
                if (walk_cnt_reg == '1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                emit_idx_next = '0;
                if (!walk_reg.valid && !upd.valid && !tgt_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    emit_idx_next = emit_idx_reg + ROW_AW'(1);
                    if (emit_idx_reg == '1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            walk_cnt_reg <= '0;
            walk_reg     <= '0;
            emit_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_cnt_reg <= walk_cnt_next;
            walk_reg     <= walk_next;
            emit_idx_reg <= emit_idx_next;
        end
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_item_reg.out_layer <= emit_idx_reg[ROW_AW-1:COORD_W];
            rsp_item_reg.out_row   <= emit_idx_reg[COORD_W-1:0];
            rsp_item_reg.out_bits  <= emit_bits;
            rsp_item_reg.last      <= (emit_idx_reg == '1);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    vvr_source_store u_source (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_xfer),
        .wr_addr ({req_item.layer_index, req_item.row_index}),
        .wr_data (req_item.row_bits),
        .rd_addr (walk_cnt_reg[WALK_W-1:COORD_W]),
        .rd_data (src_bits)
    );

    vvr_mapper u_mapper (
        .clk      (clk),
        .rst_n    (rst_n),
        .walk     (walk_reg),
        .src_bits (src_bits),
        .axis     (axis_reg),
        .sin_val  (sin_reg),
        .cos_val  (cos_reg),
        .upd      (upd)
    );

    vvr_target_store u_target (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (render_xfer),
        .upd       (upd),
        .emit_addr (emit_idx_next),
        .emit_bits (emit_bits),
        .busy      (tgt_busy)
    );

endmodule

[design/vvr_source_store.sv]
`timescale 1ns / 1ps

module vvr_source_store
    import vvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [ROW_AW-1:0]    wr_addr,
    input  logic [CUBE_EDGE-1:0] wr_data,
    input  logic [ROW_AW-1:0]    rd_addr,
    output logic [CUBE_EDGE-1:0] rd_data
);

    logic [CUBE_EDGE-1:0] src_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] src_vld_reg;
    logic [CUBE_EDGE-1:0] rd_raw_reg;
    logic                 rd_ok_reg;

    // row storage with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            src_mem[wr_addr] <= wr_data;
        end
        rd_raw_reg <= src_mem[rd_addr];
    end

    // written flags, unwritten rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                src_vld_reg[wr_addr] <= 1'b1;
            end
            rd_ok_reg <= src_vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_ok_reg ? rd_raw_reg : '0;

endmodule

[design/vvr_mapper.sv]
`timescale 1ns / 1ps

module vvr_mapper
    import vvr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  walk_t                    walk,
    input  logic [CUBE_EDGE-1:0]     src_bits,
    input  logic [AXIS_W-1:0]        axis,
    input  logic signed [TRIG_W-1:0] sin_val,
    input  logic signed [TRIG_W-1:0] cos_val,
    output upd_t                     upd
);

    // truncating /128, add centre, truncating /2
    function automatic logic signed [5:0] map_div(input logic signed [14:0] v);
        logic signed [14:0] adj;
        logic signed [7:0]  d;
        logic signed [7:0]  t;
        logic signed [7:0]  t_adj;
        adj   = v[14] ? v + 15'sd127 : v;
        d     = signed'(adj[14:7]);
        t     = d + 8'(CENTRE2);
        t_adj = t[7] ? t + 8'sd1 : t;
        return signed'(t_adj[6:1]);
    endfunction

    logic signed [4:0]  xt;
    logic signed [4:0]  yt;
    logic signed [4:0]  zt;
    logic signed [4:0]  p_val;
    logic signed [4:0]  q_val;
    logic signed [13:0] p_c;
    logic signed [13:0] q_s;
    logic signed [13:0] p_s;
    logic signed [13:0] q_c;
    logic signed [14:0] first_v;
    logic signed [14:0] second_v;
    logic signed [5:0]  first_m;
    logic signed [5:0]  second_m;
    logic signed [5:0]  tx;
    logic signed [5:0]  ty;
    logic signed [5:0]  tz;
    logic               axis_ok;
    logic               in_cube;
    upd_t               upd_next;
    upd_t               upd_reg;

    // doubled coordinates about the cube centre
    assign xt = signed'({1'b0, walk.x, 1'b0}) - 5'(CENTRE2);
    assign yt = signed'({1'b0, walk.y, 1'b0}) - 5'(CENTRE2);
    assign zt = signed'({1'b0, walk.z, 1'b0}) - 5'(CENTRE2);

    // pick the rotated pair
    always_comb
    begin
        p_val   = xt;
        q_val   = yt;
        axis_ok = 1'b1;
        case (axis)
            AXIS_XY:
            begin
                p_val = xt;
                q_val = yt;
            end
            AXIS_XZ:
            begin
                p_val = xt;
                q_val = zt;
            end
            AXIS_YZ:
            begin
                p_val = yt;
                q_val = zt;
            end
            default:
            begin
                axis_ok = 1'b0;
            end
        endcase
    end

    // rotation products
    assign p_c = p_val * cos_val;
    assign q_s = q_val * sin_val;
    assign p_s = p_val * sin_val;
    assign q_c = q_val * cos_val;

    assign first_v  = 15'(q_s) - 15'(p_c);
    assign second_v = 15'sd0 - 15'(p_s) - 15'(q_c);
    assign first_m  = map_div(first_v);
    assign second_m = map_div(second_v);

    // place the mapped pair back into x, y, z
    always_comb
    begin
        tx = signed'({3'b000, walk.x});
        ty = signed'({3'b000, walk.y});
        tz = signed'({3'b000, walk.z});
        case (axis)
            AXIS_XY:
            begin
                tx = first_m;
                ty = second_m;
            end
            AXIS_XZ:
            begin
                tx = first_m;
                tz = second_m;
            end
            AXIS_YZ:
            begin
                ty = first_m;
                tz = second_m;
            end
            default:
            begin
                tx = signed'({3'b000, walk.x});
            end
        endcase
    end

    assign in_cube = (tx[5:3] == 3'b000) && (ty[5:3] == 3'b000) && (tz[5:3] == 3'b000);

    always_comb
    begin
        upd_next.valid  = walk.valid && src_bits[walk.x] && axis_ok && in_cube;
        upd_next.addr   = {tz[2:0], ty[2:0]};
        upd_next.bitpos = tx[2:0];
    end

    // stage register after the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg <= '0;
        end
        else
        begin
            upd_reg <= upd_next;
        end
    end

    assign upd = upd_reg;

endmodule

[design/vvr_target_store.sv]
`timescale 1ns / 1ps

module vvr_target_store
    import vvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  upd_t                 upd,
    input  logic [ROW_AW-1:0]    emit_addr,
    output logic [CUBE_EDGE-1:0] emit_bits,
    output logic                 busy
);

    logic [CUBE_EDGE-1:0] tgt_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] tgt_vld_reg;
    logic [ROW_AW-1:0]    rd_addr;
    logic [CUBE_EDGE-1:0] rd_raw_reg;
    logic                 rd_ok_reg;
    logic                 wb_vld_reg;
    logic [ROW_AW-1:0]    wb_addr_reg;
    logic [COORD_W-1:0]   wb_bit_reg;
    logic                 fwd_vld_reg;
    logic [ROW_AW-1:0]    fwd_addr_reg;
    logic [CUBE_EDGE-1:0] fwd_data_reg;
    logic [CUBE_EDGE-1:0] rd_row;
    logic [CUBE_EDGE-1:0] base_row;
    logic [CUBE_EDGE-1:0] merged_row;

    // one read port shared by update reads and row output
    assign rd_addr = upd.valid ? upd.addr : emit_addr;

    assign rd_row     = rd_ok_reg ? rd_raw_reg : '0;
    // write of the previous cycle is not yet in the read data
    assign base_row   = (fwd_vld_reg && (fwd_addr_reg == wb_addr_reg)) ? fwd_data_reg : rd_row;
    assign merged_row = base_row | (CUBE_EDGE'(1) << wb_bit_reg);

    // memory read and write back
    always_ff @(posedge clk)
    begin
        rd_raw_reg <= tgt_mem[rd_addr];
        if (wb_vld_reg)
        begin
            tgt_mem[wb_addr_reg] <= merged_row;
        end
        wb_addr_reg  <= upd.addr;
        wb_bit_reg   <= upd.bitpos;
        fwd_addr_reg <= wb_addr_reg;
        fwd_data_reg <= merged_row;
    end

    // row flags cleared at once for a new frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_vld_reg <= '0;
            rd_ok_reg   <= 1'b0;
            wb_vld_reg  <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                tgt_vld_reg <= '0;
            end
            else if (wb_vld_reg)
            begin
                tgt_vld_reg[wb_addr_reg] <= 1'b1;
            end
            rd_ok_reg   <= tgt_vld_reg[rd_addr];
            wb_vld_reg  <= upd.valid;
            fwd_vld_reg <= wb_vld_reg;
        end
    end

    assign emit_bits = rd_row;
    assign busy      = wb_vld_reg;

endmodule

[design/vvr_checker.sv]
`timescale 1ns / 1ps

module vvr_checker
    import vvr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_stall,
    input in_item_t          req_item,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input out_item_t         rsp_item,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // a render transfer blocks further items
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_item.cmd == CMD_RENDER)) |=> req_stall)
        else $error("render transfer not followed by stall");

    // a load transfer leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_item.cmd == CMD_LOAD)) |=> !req_stall)
        else $error("load transfer left the block stalled");

    // nothing follows the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && rsp_item.last) |=> !rsp_valid)
        else $error("result after last row");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
        else $error("stalled result changed");

    // plane writes only while no render is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !req_stall)
        else $error("plane written during a render");

endmodule

bind voxel_volume_rotator vvr_checker u_checker (.*);
